// File: design/opr_pkg.sv
// shared constants, types and helper functions for the optimal page replacement block
`timescale 1ns / 1ps
`default_nettype none

package opr_pkg;

    localparam int MAX_FRAMES  = 8;
    localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
    localparam int NF_W        = 4;
    localparam int MAX_REFS    = 1024;
    localparam int ADDR_W      = $clog2(MAX_REFS);
    localparam int CNT_W       = 11;
    localparam int PAGE_W      = 16;
    localparam int OUT_W       = 24;
    localparam logic [NF_W-1:0] FRAMES_RESET = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIM_RD,
        ST_SIM_CHK,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DONE
    } state_t;

    typedef logic [MAX_FRAMES-1:0] frame_vec_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [FRAME_IDX_W-1:0] lowest_set(input frame_vec_t v);
        logic [FRAME_IDX_W-1:0] idx;
        idx = '0;
        for (int k = MAX_FRAMES - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                idx = FRAME_IDX_W'(k);
            end
        end
        return idx;
    endfunction

    // one bit per frame taking part in the run
    function automatic frame_vec_t active_mask(input logic [NF_W-1:0] nf);
        frame_vec_t m;
        m = '0;
        for (int k = 0; k < MAX_FRAMES; k++)
        begin
            m[k] = (k < int'(nf));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: design/optimal_page_replacement.sv
// optimal (farthest next use) page replacement fault counter over a stored reference string
// loading: one word per cycle into the reference ram, ready in idle and not during a run
// run: each reference is read and checked; a miss with all frames full and later references
//   left starts a lookahead scan (one ram read port, registered read)
// the result is loaded into an output register in the done state once that register is free, and waits there
// reset clears control state, counters and frame valid bits; the reference ram is not cleared
`timescale 1ns / 1ps
`default_nettype none

module optimal_page_replacement (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [opr_pkg::PAGE_W-1:0]    s_axis_tdata,   // [15:0] page_number
    input  wire logic                          s_axis_tlast,   // last_ref
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [opr_pkg::OUT_W-1:0]     m_axis_tdata,   // [10:0] fault_count,
                                                               // [21:11] ref_count,
                                                               // [22] overflow, [23] zero
    input  wire logic                          cfg_we,
    input  wire logic [opr_pkg::NF_W-1:0]      cfg_wdata
);

    localparam int MF     = opr_pkg::MAX_FRAMES;
    localparam int FIW    = opr_pkg::FRAME_IDX_W;
    localparam int AW     = opr_pkg::ADDR_W;
    localparam int CW     = opr_pkg::CNT_W;
    localparam int PW     = opr_pkg::PAGE_W;
    localparam int NW     = opr_pkg::NF_W;

    opr_pkg::state_t      state_reg, state_next;
    logic [NW-1:0]        frames_reg;
    logic [CW-1:0]        loaded_reg, loaded_next;
    logic                 dropped_reg, dropped_next;
    logic [AW-1:0]        i_reg, i_next;
    logic [AW-1:0]        j_reg, j_next;
    opr_pkg::frame_vec_t  found_reg, found_next;
    logic [CW-1:0]        faults_reg, faults_next;
    logic [PW-1:0]        cur_page_reg, cur_page_next;
    logic [PW-1:0]        frame_page_reg [MF];
    opr_pkg::frame_vec_t  frame_valid_reg, frame_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [opr_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic                 accept;
    logic                 run_start;
    logic [NW-1:0]        nf;
    opr_pkg::frame_vec_t  active;
    opr_pkg::frame_vec_t  match_vec;
    opr_pkg::frame_vec_t  empty_vec;
    opr_pkg::frame_vec_t  scan_hit;
    opr_pkg::frame_vec_t  found_all_vec;
    logic                 hit;
    logic                 last_pos;
    logic                 scan_end;
    logic                 found_all;
    logic                 chk_done;
    logic                 scan_done;
    logic                 step_done;
    logic                 fill_en;
    logic [FIW-1:0]       fill_idx;
    logic [PW-1:0]        fill_page;
    logic                 out_load;

    logic                 ram_we;
    logic [AW-1:0]        ram_raddr;
    logic [PW-1:0]        ram_rdata;

    opr_ram #(
        .WIDTH (PW),
        .DEPTH (opr_pkg::MAX_REFS)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (loaded_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // frame count clamped to 1..MAX_FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            nf = NW'(1);
        end
        else if (frames_reg > NW'(MF))
        begin
            nf = NW'(MF);
        end
        else
        begin
            nf = frames_reg;
        end
    end

    // parallel frame compare against the word on the ram read port
    always_comb
    begin
        active = opr_pkg::active_mask(nf);
        for (int k = 0; k < MF; k++)
        begin
            match_vec[k] = frame_valid_reg[k] && (frame_page_reg[k] == ram_rdata);
        end
        empty_vec     = active & ~frame_valid_reg;
        hit           = |(match_vec & active);
        scan_hit      = match_vec & active & ~found_reg;
        found_all_vec = found_reg | scan_hit;
        found_all     = (found_all_vec == active);
        last_pos      = ((CW'(i_reg) + CW'(1)) == loaded_reg);
        scan_end      = ((CW'(j_reg) + CW'(1)) == loaded_reg);
        chk_done      = (state_reg == opr_pkg::ST_SIM_CHK)
                        && (hit || (|empty_vec) || last_pos);
        scan_done     = (state_reg == opr_pkg::ST_SCAN_CHK) && (found_all || scan_end);
        step_done     = chk_done || scan_done;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            opr_pkg::ST_IDLE:
            begin
                if (run_start)
                begin
                    state_next = opr_pkg::ST_SIM_RD;
                end
            end
            opr_pkg::ST_SIM_RD:
            begin
                state_next = opr_pkg::ST_SIM_CHK;
            end
            opr_pkg::ST_SIM_CHK, opr_pkg::ST_SCAN_CHK:
            begin
                if (!step_done)
                begin
                    state_next = opr_pkg::ST_SCAN_RD;
                end
                else if (last_pos)
                begin
                    state_next = opr_pkg::ST_DONE;
                end
                else
                begin
                    state_next = opr_pkg::ST_SIM_RD;
                end
            end
            opr_pkg::ST_SCAN_RD:
            begin
                state_next = opr_pkg::ST_SCAN_CHK;
            end
            opr_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = opr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = opr_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == opr_pkg::ST_IDLE);
        accept        = s_axis_tvalid && s_axis_tready;
        run_start     = accept && s_axis_tlast;
        ram_we        = accept && (loaded_reg < CW'(opr_pkg::MAX_REFS));
        ram_raddr     = (state_reg == opr_pkg::ST_SCAN_RD) ? j_reg : i_reg;
        out_load      = (state_reg == opr_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = out_data_reg;
    end

    // frame fill or victim choice
    always_comb
    begin
        fill_en   = 1'b0;
        fill_idx  = '0;
        fill_page = cur_page_reg;
        if (chk_done && !hit)
        begin
            fill_en   = 1'b1;
            fill_page = ram_rdata;
            // lowest empty frame; if none, no later use: all qualify, lowest wins
            fill_idx  = (|empty_vec) ? opr_pkg::lowest_set(empty_vec) : '0;
        end
        else if (scan_done)
        begin
            fill_en = 1'b1;
            if (found_all)
            begin
                // the frame found last has the farthest next use
                fill_idx = opr_pkg::lowest_set(scan_hit);
            end
            else
            begin
                fill_idx = opr_pkg::lowest_set(active & ~found_all_vec);
            end
        end
    end

    // datapath next values
    always_comb
    begin
        loaded_next      = loaded_reg;
        dropped_next     = dropped_reg;
        i_next           = i_reg;
        j_next           = j_reg;
        found_next       = found_reg;
        faults_next      = faults_reg;
        cur_page_next    = cur_page_reg;
        frame_valid_next = frame_valid_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (ram_we)
            begin
                loaded_next = loaded_reg + CW'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end

        if (run_start)
        begin
            i_next           = '0;
            faults_next      = '0;
            frame_valid_next = '0;
        end

        if (state_reg == opr_pkg::ST_SIM_CHK)
        begin
            cur_page_next = ram_rdata;
            if (!step_done)
            begin
                j_next     = i_reg + AW'(1);
                found_next = '0;
            end
        end

        if (state_reg == opr_pkg::ST_SCAN_CHK && !step_done)
        begin
            found_next = found_all_vec;
            j_next     = j_reg + AW'(1);
        end

        if (fill_en)
        begin
            frame_valid_next[fill_idx] = 1'b1;
            faults_next                = faults_reg + CW'(1);
        end

        if (step_done && !last_pos)
        begin
            i_next = i_reg + AW'(1);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {1'b0, dropped_reg, loaded_reg, faults_reg};
            loaded_next    = '0;
            dropped_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= opr_pkg::ST_IDLE;
            frames_reg      <= opr_pkg::FRAMES_RESET;
            loaded_reg      <= '0;
            dropped_reg     <= 1'b0;
            i_reg           <= '0;
            j_reg           <= '0;
            found_reg       <= '0;
            faults_reg      <= '0;
            frame_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            if (cfg_we)
            begin
                frames_reg <= cfg_wdata;
            end
            loaded_reg      <= loaded_next;
            dropped_reg     <= dropped_next;
            i_reg           <= i_next;
            j_reg           <= j_next;
            found_reg       <= found_next;
            faults_reg      <= faults_next;
            frame_valid_reg <= frame_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_page_reg <= cur_page_next;
        out_data_reg <= out_data_next;
        if (fill_en)
        begin
            frame_page_reg[fill_idx] <= fill_page;
        end
    end

endmodule

`default_nettype wire

// File: design/opr_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module opr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
